// ===== hw/rtl/scrsc_pkg.sv =====
package scrsc_pkg;

    localparam int MAX_ROW_ENTRIES = 256;
    localparam int COLUMN_BITS     = 32;
    localparam int WINDOW_BITS     = 32;

    // entry index within one bank, and a length that can hold the full depth
    localparam int ROW_IDX_BITS = $clog2(MAX_ROW_ENTRIES);
    localparam int LEN_BITS     = ROW_IDX_BITS + 1;
    localparam int STORE_ADDR_BITS = ROW_IDX_BITS + 1;
    localparam int STORE_DEPTH     = 2 * MAX_ROW_ENTRIES;

    // result payload on the master side
    localparam int OUT_FIELD_BITS = 2 * LEN_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_USER_BITS  = 2;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    typedef struct packed {
        logic [LEN_BITS-1:0] matched_count;
        logic [LEN_BITS-1:0] row_degree;
        logic                has_successor;
        logic                overflowed;
        logic                final_result;
    } result_t;

endpackage

// ===== hw/rtl/sparse_cross_row_similarity_count_core.sv =====
// sequence: accept while idle, scan the buffered row, then a closing step that stores the column;
// a result is presented in the emit state that follows the closing step
// throughput: a new request is taken only once idle again, after its scan over the buffered
// entries it passes (at most MAX_ROW_ENTRIES over a whole row) and after its results are taken
// reset: rst_n is asynchronous, active low; clears all control state and sets window to 1;
// row store contents are not cleared and need no clearing pass
module sparse_cross_row_similarity_count_core
    import scrsc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    // configuration: window register
    input  logic                     window_wr_en,
    input  logic [WINDOW_BITS-1:0]   window_wr_data,

    // request side
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [COLUMN_BITS-1:0]   s_tdata,   // column
    input  logic                     s_tlast,   // row_end
    input  logic                     s_tuser,   // matrix_end

    // result side
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,   // matched_count, row_degree, zero fill
    output logic [OUT_USER_BITS-1:0] m_tuser,   // has_successor, overflowed
    output logic                     m_tlast    // final_result
);

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    logic [1:0]             state_reg, state_next;
    logic [WINDOW_BITS-1:0] window_reg, window_next;
    logic [LEN_BITS-1:0]    prev_len_reg, prev_len_next;
    logic [LEN_BITS-1:0]    cur_len_reg, cur_len_next;
    logic [LEN_BITS-1:0]    scan_reg, scan_next;
    logic [LEN_BITS-1:0]    tally_reg, tally_next;
    logic                   prev_present_reg, prev_present_next;
    logic                   bank_reg, bank_next;
    logic [1:0]             ovf_marks_reg, ovf_marks_next;
    logic                   pending_b_reg, pending_b_next;

    // ------------------------------------------------------------------
    // payload registers (no reset)
    // ------------------------------------------------------------------
    logic [COLUMN_BITS-1:0] column_reg, column_next;
    logic                   row_end_reg, row_end_next;
    logic                   matrix_end_reg, matrix_end_next;
    result_t                out_reg, out_next;
    result_t                out_b_reg, out_b_next;

    // ------------------------------------------------------------------
    // row store: two banks, one write and one registered read per cycle
    // ------------------------------------------------------------------
    logic [COLUMN_BITS-1:0]     row_store [STORE_DEPTH];
    logic [COLUMN_BITS-1:0]     rd_data_reg;
    logic [STORE_ADDR_BITS-1:0] rd_addr;
    logic [STORE_ADDR_BITS-1:0] wr_addr;
    logic                       wr_en;

    // ------------------------------------------------------------------
    // shared compare unit: one |c - p| against the window per cycle
    // ------------------------------------------------------------------
    logic                   scan_active;
    logic                   col_ge;
    logic [COLUMN_BITS-1:0] diff_fwd;
    logic [COLUMN_BITS-1:0] diff_rev;
    logic [COLUMN_BITS-1:0] abs_diff;
    logic                   step_match;
    logic                   step_advance;

    // closing-cycle helpers
    logic                   row_full;
    logic [LEN_BITS-1:0]    len_after;
    logic [1:0]             marks_after;
    logic                   closing;
    result_t                res_a;
    result_t                res_b;

    assign scan_active  = prev_present_reg && (scan_reg < prev_len_reg);
    assign col_ge       = column_reg >= rd_data_reg;
    assign diff_fwd     = column_reg - rd_data_reg;
    assign diff_rev     = rd_data_reg - column_reg;
    assign abs_diff     = col_ge ? diff_fwd : diff_rev;
    assign step_match   = abs_diff <= window_reg;
    // a buffered entry far below the column is passed without counting
    assign step_advance = col_ge || step_match;

    // store the incoming column unless the row has filled its bank
    assign row_full    = cur_len_reg >= LEN_BITS'(MAX_ROW_ENTRIES);
    assign len_after   = row_full ? cur_len_reg : cur_len_reg + LEN_BITS'(1);
    assign marks_after = ovf_marks_reg | {row_full, 1'b0};
    assign closing     = row_end_reg || matrix_end_reg;

    // buffered row compared against its successor
    always_comb
    begin
        res_a.matched_count = tally_reg;
        res_a.row_degree    = prev_len_reg;
        res_a.has_successor = 1'b1;
        res_a.overflowed    = marks_after != 2'b00;
        res_a.final_result  = !matrix_end_reg;
    end

    // last row of the matrix, no successor
    always_comb
    begin
        res_b.matched_count = '0;
        res_b.row_degree    = len_after;
        res_b.has_successor = 1'b0;
        res_b.overflowed    = marks_after[1];
        res_b.final_result  = 1'b1;
    end

    // the scan ends this cycle: write the column and close the row if flagged
    assign wr_en   = (state_reg == ST_SCAN) && !(scan_active && step_advance) && !row_full;
    assign wr_addr = {bank_reg, cur_len_reg[ROW_IDX_BITS-1:0]};
    // read is addressed by the next scan position through a registered read, so each step sees its entry;
    // the buffered bank is the one not taking writes
    assign rd_addr = {~bank_next, scan_next[ROW_IDX_BITS-1:0]};

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        window_next       = window_reg;
        prev_len_next     = prev_len_reg;
        cur_len_next      = cur_len_reg;
        scan_next         = scan_reg;
        tally_next        = tally_reg;
        prev_present_next = prev_present_reg;
        bank_next         = bank_reg;
        ovf_marks_next    = ovf_marks_reg;
        pending_b_next    = pending_b_reg;
        column_next       = column_reg;
        row_end_next      = row_end_reg;
        matrix_end_next   = matrix_end_reg;
        out_next          = out_reg;
        out_b_next        = out_b_reg;

        // configuration must be written only while idle; the block itself does not enforce it
        if (window_wr_en)
        begin
            window_next = window_wr_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    column_next     = s_tdata;
                    row_end_next    = s_tlast;
                    matrix_end_next = s_tuser;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (scan_active && step_advance)
                begin
                    // one buffered entry per cycle
                    scan_next = scan_reg + LEN_BITS'(1);
                    if (step_match)
                    begin
                        tally_next = tally_reg + LEN_BITS'(1);
                    end
                end
                else
                begin
                    // scan stopped: column is stored unless the bank is full, row closed if flagged
                    cur_len_next   = len_after;
                    ovf_marks_next = marks_after;
                    state_next     = ST_IDLE;

                    if (closing)
                    begin
                        bank_next         = ~bank_reg;
                        prev_len_next     = len_after;
                        ovf_marks_next    = {1'b0, marks_after[1]};
                        prev_present_next = 1'b1;
                        cur_len_next      = '0;
                        scan_next         = '0;
                        tally_next        = '0;
                    end

                    if (matrix_end_reg)
                    begin
                        // back to an empty buffer for the next matrix
                        prev_present_next = 1'b0;
                        prev_len_next     = '0;
                        ovf_marks_next    = '0;
                    end

                    if (closing && prev_present_reg)
                    begin
                        out_next       = res_a;
                        out_b_next     = res_b;
                        pending_b_next = matrix_end_reg;
                        state_next     = ST_EMIT;
                    end
                    else if (matrix_end_reg)
                    begin
                        out_next       = res_b;
                        pending_b_next = 1'b0;
                        state_next     = ST_EMIT;
                    end
                end
            end

            ST_EMIT:
            begin
                if (m_tready)
                begin
                    if (pending_b_reg)
                    begin
                        out_next       = out_b_reg;
                        pending_b_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            window_reg       <= WINDOW_BITS'(1);
            prev_len_reg     <= '0;
            cur_len_reg      <= '0;
            scan_reg         <= '0;
            tally_reg        <= '0;
            prev_present_reg <= 1'b0;
            bank_reg         <= 1'b0;
            ovf_marks_reg    <= '0;
            pending_b_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            window_reg       <= window_next;
            prev_len_reg     <= prev_len_next;
            cur_len_reg      <= cur_len_next;
            scan_reg         <= scan_next;
            tally_reg        <= tally_next;
            prev_present_reg <= prev_present_next;
            bank_reg         <= bank_next;
            ovf_marks_reg    <= ovf_marks_next;
            pending_b_reg    <= pending_b_next;
        end
    end

    // ------------------------------------------------------------------
    // payload registers and row store
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        column_reg     <= column_next;
        row_end_reg    <= row_end_next;
        matrix_end_reg <= matrix_end_next;
        out_reg        <= out_next;
        out_b_reg      <= out_b_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_store[wr_addr] <= column_reg;
        end
        rd_data_reg <= row_store[rd_addr];
    end

    // ------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------
    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = state_reg == ST_EMIT;
    assign m_tdata  = {{(OUT_DATA_BITS - OUT_FIELD_BITS){1'b0}},
                       out_reg.row_degree, out_reg.matched_count};
    assign m_tuser  = {out_reg.overflowed, out_reg.has_successor};
    assign m_tlast  = out_reg.final_result;

endmodule

// ===== sim/tb_sparse_cross_row_similarity_count_core.sv =====
`timescale 1ns / 1ps

module tb_sparse_cross_row_similarity_count_core;
    import scrsc_pkg::*;

    // clock and reset
    logic clk;
    logic rst_n;

    // window register write port
    logic                     window_wr_en;
    logic [WINDOW_BITS-1:0]   window_wr_data;

    // request side
    logic                     s_tvalid;
    logic                     s_tready;
    logic [COLUMN_BITS-1:0]   s_tdata;   // column
    logic                     s_tlast;   // row_end
    logic                     s_tuser;   // matrix_end

    // result side
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;   // matched_count, row_degree, zero fill
    logic [OUT_USER_BITS-1:0] m_tuser;   // has_successor, overflowed
    logic                     m_tlast;   // final_result

    // settle time after the last result: a scan over a full row plus margin
    localparam int SETTLE_CYCLES   = MAX_ROW_ENTRIES + 16;
    localparam int HOLD_CYCLES     = 400;
    localparam int PHASE_REQUESTS  = 220;
    localparam int NUM_PHASES      = 6;
    localparam result_t NO_REPORT  = '0;

    // one line of the directed stimulus; typed rows carry their reports
    typedef struct packed {
        logic [COLUMN_BITS-1:0] column;
        logic                   row_end;
        logic                   matrix_end;
        logic                   typed;
        logic [1:0]             typed_count;
        result_t                first;
        result_t                second;
    } directed_row_t;

    directed_row_t directed_rows [20] = '{
        // single-entry matrix straight after reset, window at its reset value
        '{32'd5,          1'b1, 1'b1, 1'b1, 2'd1, '{9'd0, 9'd1, 1'b0, 1'b0, 1'b1}, NO_REPORT},
        // matrix end without row end closes a two-entry row at the column extremes
        '{32'd0,          1'b0, 1'b0, 1'b1, 2'd0, NO_REPORT, NO_REPORT},
        '{32'hFFFF_FFFF,  1'b0, 1'b1, 1'b1, 2'd1, '{9'd0, 9'd2, 1'b0, 1'b0, 1'b1}, NO_REPORT},
        // two close rows, then a far one ending the matrix, which yields two reports
        '{32'd10,         1'b0, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
        '{32'd20,         1'b1, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
        '{32'd11,         1'b0, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
        '{32'd21,         1'b1, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
        '{32'hFFFF_FFFF,  1'b1, 1'b1, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
        // unsorted columns, then matrix end without row end
        '{32'd100,        1'b0, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
        '{32'd50,         1'b0, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
        '{32'd200,        1'b1, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
        '{32'd49,         1'b0, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
        '{32'd101,        1'b0, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
        '{32'd300,        1'b0, 1'b1, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
        // requests after matrix end start afresh; equal and neighbouring columns
        '{32'd7,          1'b1, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
        '{32'd7,          1'b1, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
        '{32'd8,          1'b1, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
        '{32'd6,          1'b1, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
        // top bit crossing: distance one across the half-range boundary
        '{32'h8000_0000,  1'b1, 1'b0, 1'b0, 2'd0, NO_REPORT, NO_REPORT},
        '{32'h7FFF_FFFF,  1'b1, 1'b1, 1'b0, 2'd0, NO_REPORT, NO_REPORT}
    };

    // predictor state: two banks, one for the kept row, one for the row arriving
    logic [COLUMN_BITS-1:0] row_bank [0:1][0:MAX_ROW_ENTRIES-1];
    int unsigned            kept_len;
    int unsigned            open_len;
    int unsigned            scan_idx;
    int unsigned            hit_count;
    bit                     kept_valid;
    bit                     open_bank;
    bit [1:0]               spill;       // bit 0 kept row, bit 1 arriving row
    logic [WINDOW_BITS-1:0] window_now;
    result_t                step_reports [0:1];

    result_t pending_reports [$];
    result_t head_report;
    int      errors;
    int      requests_sent;
    int      burst_left;
    bit      hold_request;

    sparse_cross_row_similarity_count_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .window_wr_en   (window_wr_en),
        .window_wr_data (window_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // walk the kept row against one new column, store it, close rows and matrices
    function automatic int similarity_step(input logic [COLUMN_BITS-1:0] col,
                                           input logic row_end,
                                           input logic matrix_end);
        int                     n;
        logic [COLUMN_BITS-1:0] p;
        bit                     kept_bank;
        n = 0;
        kept_bank = ~open_bank;
        if (kept_valid)
        begin
            while (scan_idx < kept_len)
            begin
                p = row_bank[kept_bank][scan_idx];
                if (col >= p)
                begin
                    // column at or past the kept entry: count if close, always move on
                    if (col - p <= window_now)
                        hit_count++;
                    scan_idx++;
                end
                else if (p - col <= window_now)
                begin
                    hit_count++;
                    scan_idx++;
                end
                else
                    break;   // kept entry lies ahead, wait for a later column
            end
        end

        if (open_len < MAX_ROW_ENTRIES)
        begin
            row_bank[open_bank][open_len] = col;
            open_len++;
        end
        else
            spill[1] = 1'b1;   // buffer full, entry compared but dropped

        if (row_end || matrix_end)
        begin
            if (kept_valid)
            begin
                step_reports[n] = '{LEN_BITS'(hit_count), LEN_BITS'(kept_len), 1'b1,
                                    |spill, 1'b0};
                n++;
            end
            open_bank  = kept_bank;
            kept_len   = open_len;
            spill      = {1'b0, spill[1]};
            kept_valid = 1'b1;
            open_len   = 0;
            scan_idx   = 0;
            hit_count  = 0;
        end

        if (matrix_end)
        begin
            // last row of the matrix has nothing to compare against
            step_reports[n] = '{'0, LEN_BITS'(kept_len), 1'b0, spill[0], 1'b0};
            n++;
            kept_valid = 1'b0;
            kept_len   = 0;
            spill      = '0;
        end

        if (n > 0)
            step_reports[n-1].final_result = 1'b1;
        return n;
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    // offer one request in the current burst; predict its reports once taken
    task automatic send_request(input logic [COLUMN_BITS-1:0] col, input logic row_end,
                                input logic matrix_end, input bit typed, input int typed_n,
                                input result_t t0, input result_t t1);
        int n;
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 30 : 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 300)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= col;
        s_tlast  <= row_end;
        s_tuser  <= matrix_end;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        requests_sent++;
        n = similarity_step(col, row_end, matrix_end);
        if (typed)
        begin
            if (typed_n > 0)
                pending_reports.push_back(t0);
            if (typed_n > 1)
                pending_reports.push_back(t1);
        end
        else
        begin
            for (int i = 0; i < n; i++)
                pending_reports.push_back(step_reports[i]);
        end
        burst_left--;
        if (burst_left == 0)
            s_tvalid <= 1'b0;
    endtask

    // withdraw the request side and wait for the block to fall idle
    task automatic wait_drained();
        if (burst_left != 0)
        begin
            s_tvalid <= 1'b0;
            burst_left = 0;
        end
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input logic [WINDOW_BITS-1:0] value);
        wait_drained();
        window_wr_en   <= 1'b1;
        window_wr_data <= value;
        @(posedge clk);
        window_wr_en   <= 1'b0;
        window_now = value;
    endtask

    // one row of ascending columns with random steps, a little noise mixed in
    task automatic send_row(input int len, input logic [COLUMN_BITS-1:0] start,
                            input int unsigned gap_max, input bit closes_matrix);
        logic [COLUMN_BITS-1:0] col;
        logic [COLUMN_BITS-1:0] value;
        logic                   row_end;
        logic                   matrix_end;
        col = start + $urandom_range(0, gap_max);
        for (int i = 0; i < len; i++)
        begin
            value      = ($urandom_range(0, 99) < 6) ? $urandom() : col;
            row_end    = (i == len - 1);
            matrix_end = 1'b0;
            if (row_end && closes_matrix)
            begin
                // now and then the matrix ends without its row end mark
                matrix_end = 1'b1;
                row_end    = ($urandom_range(0, 3) != 0);
            end
            send_request(value, row_end, matrix_end, 1'b0, 0, NO_REPORT, NO_REPORT);
            col = col + $urandom_range(0, gap_max);
        end
    endtask

    // result side: stall pattern of its own, plus one long hold-off on demand
    initial
    begin : result_sink
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        m_tready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // compare every accepted report with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t unexpected report: expected none, got count %0d degree %0d",
                         $time, m_tdata[LEN_BITS-1:0], m_tdata[2*LEN_BITS-1:LEN_BITS]);
                errors++;
            end
            else
            begin
                head_report = pending_reports.pop_front();
                check_field("matched_count", head_report.matched_count,
                            m_tdata[LEN_BITS-1:0]);
                check_field("row_degree", head_report.row_degree,
                            m_tdata[2*LEN_BITS-1:LEN_BITS]);
                check_field("has_successor", head_report.has_successor, m_tuser[0]);
                check_field("overflowed", head_report.overflowed, m_tuser[1]);
                check_field("final_result", head_report.final_result, m_tlast);
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        int                     target;
        int                     n_rows;
        int                     len;
        int unsigned            gap_max;
        logic [COLUMN_BITS-1:0] base;
        logic [WINDOW_BITS-1:0] win;

        // everything known from time zero
        rst_n          = 1'b0;
        window_wr_en   = 1'b0;
        window_wr_data = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        s_tuser        = 1'b0;
        errors         = 0;
        requests_sent  = 0;
        burst_left     = 0;
        hold_request   = 1'b0;
        kept_len       = 0;
        open_len       = 0;
        scan_idx       = 0;
        hit_count      = 0;
        kept_valid     = 1'b0;
        open_bank      = 1'b0;
        spill          = '0;
        window_now     = 32'd1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset window
        foreach (directed_rows[i])
            send_request(directed_rows[i].column, directed_rows[i].row_end,
                         directed_rows[i].matrix_end, directed_rows[i].typed,
                         directed_rows[i].typed_count, directed_rows[i].first,
                         directed_rows[i].second);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:       win = 32'd2;
                1:       win = 32'd0;
                2:       win = 32'hFFFF_FFFF;
                3:       win = 32'd1;
                4:       win = $urandom_range(3, 40);
                default: win = $urandom();
            endcase
            set_window(win);
            // steps between columns scaled to the window so that matches are common
            gap_max = (window_now >= 32'h0100_0000) ? 32'h0100_0000 : window_now * 2 + 2;

            if (ph == 0)
            begin
                // rows over and at the buffer size, reported and compared both ways
                base = $urandom_range(0, 1000);
                send_row(3, base, gap_max, 1'b0);
                send_row(MAX_ROW_ENTRIES + 1, base, gap_max, 1'b0);
                send_row(MAX_ROW_ENTRIES, base, gap_max, 1'b0);
                send_row(3, base, gap_max, 1'b1);
            end
            if (ph == 3)
                hold_request = 1'b1;   // result side backs up while requests keep coming

            target = requests_sent + PHASE_REQUESTS;
            while (requests_sent < target)
            begin
                n_rows = $urandom_range(1, 8);
                case ($urandom_range(0, 3))
                    0:       base = $urandom_range(0, 64);
                    3:       base = 32'hFFFF_FFFF - $urandom_range(0, 300);
                    default: base = $urandom();
                endcase
                for (int r = 0; r < n_rows; r++)
                begin
                    len = ($urandom_range(0, 199) == 0) ? $urandom_range(250, 260)
                                                        : $urandom_range(1, 10);
                    send_row(len, base, gap_max, r == n_rows - 1);
                end
            end
        end

        wait_drained();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
